@@ rtl/lcd_window_pixel_stream_top_macros.svh @@
// ----------------------------------------------------------------------------
// lcd_window_pixel_stream_top_macros.svh
// Assertion macros used by the checker file of the LCD byte streamer.
// ----------------------------------------------------------------------------
`ifndef LCD_WINDOW_PIXEL_STREAM_TOP_MACROS_SVH
`define LCD_WINDOW_PIXEL_STREAM_TOP_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define LCDW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while rst_n is low.
`define LCDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/lcdw_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdw_pkg
// Types and constants of the LCD window / pixel byte streamer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdw_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_WINDOW = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_GLYPH  = 2'd2;

    // configuration register indexes
    localparam logic CFG_COL_OFFSET = 1'b0;
    localparam logic CFG_ROW_OFFSET = 1'b1;

    localparam logic [1:0] COL_OFFSET_RESET = 2'd2;
    localparam logic [1:0] ROW_OFFSET_RESET = 2'd1;

    // controller commands
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;
    localparam logic [7:0] ADDR_HIGH = 8'h00;

    localparam int unsigned JOB_FIFO_DEPTH = 2;

    // byte sequencer
    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] WIN_LAST_STEP    = 5'd10;
    localparam logic [STEP_W-1:0] PIX_LAST_STEP    = 5'd1;
    localparam logic [STEP_W-1:0] GLYPH8_LAST_STEP = 5'd15;
    localparam logic [STEP_W-1:0] GLYPH16_LAST_STEP = 5'd31;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic [15:0] fore_color;
        logic [15:0] back_color;
        logic [15:0] glyph_bits;
        logic        glyph_wide;
    } s_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } m_item_t;

    typedef enum logic [1:0] {
        JOB_WINDOW,
        JOB_PIXEL,
        JOB_GLYPH
    } job_kind_t;

    // WINDOW: word_a = {x start, x end}, word_b = {y start, y end}, offsets applied
    // PIXEL:  word_a = colour
    // GLYPH:  word_a = foreground, word_b = background
    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] bits;
        logic        wide;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

@@ rtl/lcd_window_pixel_stream_top.sv @@
// ----------------------------------------------------------------------------
// lcd_window_pixel_stream_top
// An accepted item's first byte goes through the job queue, then the output register, to m_valid.
// The byte sequencer gives one byte per cycle while the receiver does not stall it; a window is 11 bytes,
// a pixel tick 2, a glyph row 16 or 32; ticks with nothing to send and code 3 send none.
// Reset (aresetn low, synchronous): offsets to 2/1, pixel count and fill colour to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_window_pixel_stream_top import lcdw_pkg::*; #(
    parameter int unsigned JOB_DEPTH = JOB_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    // drawing requests
    input  logic       s_valid,
    output logic       s_ready,
    input  s_item_t    s_item,
    // link bytes
    output logic       m_valid,
    input  logic       m_ready,
    output m_item_t    m_item,
    // configuration writes (column / row offset)
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [1:0] cfg_wdata
);

    // Front: decodes the action, updates the pixel count and fill colour at
    // accept time and turns each byte-producing item into a job. Because the
    // job carries the colour and offset coordinates already resolved, the
    // state may run ahead of the bytes still queued behind it.
    job_t       job_in, job_head;
    logic       job_push, job_pop;
    fifo_stat_t fifo_stat;

    lcdw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .fifo_stat (fifo_stat),
        .job_push  (job_push),
        .job       (job_in)
    );

    // Job queue: lets the front keep taking items while a long job drains.
    lcdw_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job_in),
        .pop      (job_pop),
        .head_job (job_head),
        .stat     (fifo_stat)
    );

    // Back: steps through the head job, one byte per cycle into the output
    // register while the receiver does not stall it; pops the job with its last
    // byte so the next one follows without a gap.
    lcdw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (job_head),
        .fifo_stat (fifo_stat),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

@@ rtl/lcdw_front.sv @@
// ----------------------------------------------------------------------------
// lcdw_front
// Accepts items, keeps window state and offsets, and issues byte jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdw_front import lcdw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  s_item_t    s_item,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [1:0] cfg_wdata,
    input  fifo_stat_t fifo_stat,
    output logic       job_push,
    output job_t       job
);

    logic [1:0]  col_off_reg, row_off_reg;
    logic [16:0] pixels_left_reg, pixels_left_next;
    logic [15:0] fill_color_reg, fill_color_next;

    logic        accept;
    logic [8:0]  width, height;
    logic [16:0] area;
    logic [16:0] area_count;

    assign s_ready = !fifo_stat.full;
    assign accept  = s_valid && s_ready;

    assign width  = 9'(s_item.x_end) - 9'(s_item.x_start) + 9'd1;
    assign height = 9'(s_item.y_end) - 9'(s_item.y_start) + 9'd1;
    // 256 x 256 still fits; reversed corners are discarded below
    assign area   = 17'(width) * 17'(height);
    assign area_count = (s_item.x_end < s_item.x_start || s_item.y_end < s_item.y_start)
                        ? 17'd0 : area;

    always_comb begin
        pixels_left_next = pixels_left_reg;
        fill_color_next  = fill_color_reg;
        job_push         = 1'b0;
        job.kind         = JOB_GLYPH;
        job.word_a       = s_item.fore_color;
        job.word_b       = s_item.back_color;
        job.bits         = s_item.glyph_bits;
        job.wide         = s_item.glyph_wide;
        if (accept) begin
            unique case (s_item.action)
                ACT_WINDOW: begin
                    job_push         = 1'b1;
                    job.kind         = JOB_WINDOW;
                    job.word_a       = {s_item.x_start + 8'(col_off_reg),
                                        s_item.x_end + 8'(col_off_reg)};
                    job.word_b       = {s_item.y_start + 8'(row_off_reg),
                                        s_item.y_end + 8'(row_off_reg)};
                    pixels_left_next = area_count;
                    fill_color_next  = s_item.fore_color;
                end
                ACT_TICK: begin
                    job.kind   = JOB_PIXEL;
                    job.word_a = fill_color_reg;
                    if (pixels_left_reg != 17'd0) begin
                        job_push         = 1'b1;
                        pixels_left_next = pixels_left_reg - 17'd1;
                    end
                end
                ACT_GLYPH: begin
                    job_push = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_off_reg     <= COL_OFFSET_RESET;
            row_off_reg     <= ROW_OFFSET_RESET;
            pixels_left_reg <= '0;
            fill_color_reg  <= '0;
        end else begin
            pixels_left_reg <= pixels_left_next;
            fill_color_reg  <= fill_color_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_COL_OFFSET: col_off_reg <= cfg_wdata;
                    CFG_ROW_OFFSET: row_off_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/lcdw_job_fifo.sv @@
// ----------------------------------------------------------------------------
// lcdw_job_fifo
// Short job queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdw_job_fifo import lcdw_pkg::*; #(
    parameter int unsigned DEPTH = JOB_FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  job_t       push_job,
    input  logic       pop,
    output job_t       head_job,
    output fifo_stat_t stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign head_job   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/lcdw_back.sv @@
// ----------------------------------------------------------------------------
// lcdw_back
// Byte sequencer: expands the head job into link bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdw_back import lcdw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       head_job,
    input  fifo_stat_t fifo_stat,
    output logic       job_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output m_item_t    m_item
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] last_step;
    logic              advance;
    logic              at_last;
    logic [15:0]       glyph_color;
    m_item_t           m_item_reg, m_item_next;
    logic              m_valid_reg;

    assign advance = !fifo_stat.empty && (!m_valid_reg || m_ready);
    assign at_last = (step_reg == last_step);
    assign job_pop = advance && at_last;

    // bit 0 of the step picks high or low byte, the rest picks the bitmap bit
    assign glyph_color = head_job.bits[step_reg[STEP_W-1:1]] ? head_job.word_a
                                                             : head_job.word_b;

    always_comb begin
        unique case (head_job.kind)
            JOB_WINDOW: last_step = WIN_LAST_STEP;
            JOB_PIXEL:  last_step = PIX_LAST_STEP;
            JOB_GLYPH:  last_step = head_job.wide ? GLYPH16_LAST_STEP : GLYPH8_LAST_STEP;
            default:    last_step = PIX_LAST_STEP;
        endcase
    end

    always_comb begin
        m_item_next.is_data  = 1'b1;
        m_item_next.last     = at_last;
        m_item_next.out_byte = ADDR_HIGH;
        unique case (head_job.kind)
            JOB_WINDOW: begin
                unique case (step_reg)
                    5'd0: begin
                        m_item_next.out_byte = CMD_CASET;
                        m_item_next.is_data  = 1'b0;
                    end
                    5'd2: m_item_next.out_byte = head_job.word_a[15:8];
                    5'd4: m_item_next.out_byte = head_job.word_a[7:0];
                    5'd5: begin
                        m_item_next.out_byte = CMD_RASET;
                        m_item_next.is_data  = 1'b0;
                    end
                    5'd7: m_item_next.out_byte = head_job.word_b[15:8];
                    5'd9: m_item_next.out_byte = head_job.word_b[7:0];
                    5'd10: begin
                        m_item_next.out_byte = CMD_RAMWR;
                        m_item_next.is_data  = 1'b0;
                    end
                    default: m_item_next.out_byte = ADDR_HIGH;
                endcase
            end
            JOB_PIXEL: begin
                m_item_next.out_byte = step_reg[0] ? head_job.word_a[7:0]
                                                   : head_job.word_a[15:8];
            end
            JOB_GLYPH: begin
                m_item_next.out_byte = step_reg[0] ? glyph_color[7:0] : glyph_color[15:8];
            end
            default: m_item_next.out_byte = ADDR_HIGH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg <= m_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            if (advance) begin
                m_valid_reg <= 1'b1;
                step_reg    <= at_last ? '0 : step_reg + STEP_W'(1);
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ rtl/lcdw_checker.sv @@
// ----------------------------------------------------------------------------
// lcdw_checker
// Port-level checks of the LCD byte streamer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcd_window_pixel_stream_top_macros.svh"

module lcdw_checker import lcdw_pkg::*; (
    input logic    aclk,
    input logic    aresetn,
    input logic    m_valid,
    input logic    m_ready,
    input m_item_t m_item
);

    // output held while stalled
    `LCDW_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))

    // reset empties the output register
    `LCDW_ASSERT_NEXT(a_rst_empty, aclk, 1'b1, !aresetn, !m_valid)

    // command bytes are only the three address / write commands
    `LCDW_ASSERT_SAME(a_cmd_code, aclk, aresetn, m_valid && !m_item.is_data, m_item.out_byte == CMD_CASET || m_item.out_byte == CMD_RASET || m_item.out_byte == CMD_RAMWR)

    // memory-write command closes its window sequence, the other commands never do
    `LCDW_ASSERT_SAME(a_cmd_last, aclk, aresetn, m_valid && !m_item.is_data, m_item.last == (m_item.out_byte == CMD_RAMWR))

endmodule

bind lcd_window_pixel_stream_top lcdw_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LCD window / pixel byte streamer. A directed
// table walks the corner cases at the reset offsets. Random phases follow,
// each under its own column / row offset setting. Every link byte is checked
// against an in-bench model of the address, pixel and glyph byte sequences.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import lcdw_pkg::*;

    // action code 3 has no meaning in the block; it must be swallowed
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_REQUESTS = 30;      // random requests with output, per phase
    localparam int MAX_REPORTS    = 40;

    // one row of the directed table; typed rows carry their expected bytes
    // (pixel colour bytes, or nothing at all), the rest go through the model
    typedef struct packed {
        s_item_t     item;
        logic        typed;
        logic [1:0]  typed_n;
        logic [15:0] typed_word;
    } opening_row_t;

    logic    aclk      = 1'b0;
    logic    aresetn   = 1'b0;
    logic    s_valid   = 1'b0;
    logic    s_ready;
    s_item_t s_item    = '0;
    logic    m_valid;
    logic    m_ready   = 1'b0;
    m_item_t m_item;
    logic    cfg_wr_en = 1'b0;
    logic    cfg_index = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;

    // model state: offsets plus the pending window
    logic [1:0]  col_offset_q   = COL_OFFSET_RESET;
    logic [1:0]  row_offset_q   = ROW_OFFSET_RESET;
    logic [16:0] pixels_pending = '0;
    logic [15:0] fill_rgb       = '0;

    m_item_t      link_bytes_due[$];   // bytes still owed on the link, oldest first
    m_item_t      link_want;
    opening_row_t opening_rows[$];

    int cycle_count    = 0;
    int mismatches     = 0;
    int bytes_checked  = 0;
    int items_accepted = 0;
    int items_with_out = 0;
    int windows_sent   = 0;
    int ticks_sent     = 0;
    int glyphs_sent    = 0;
    int ignored_sent   = 0;
    int offset_sets    = 1;
    int burst_left     = 0;

    // receiver stall pattern
    logic [1:0] stall_mode = 2'd0;
    int         stall_hold = 0;
    logic [1:0] slow_phase = 2'd0;

    lcd_window_pixel_stream_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // Model of the byte stream
    // ------------------------------------------------------------------------
    function automatic m_item_t make_byte(input logic [7:0] b, input logic d,
                                          input logic l);
        m_item_t r;
        r.out_byte = b;
        r.is_data  = d;
        r.last     = l;
        return r;
    endfunction

    // Works out the bytes one request causes and advances the model state.
    // With queue_it low only the state moves (typed rows bring their own bytes).
    function automatic int expand_request(input s_item_t it, input bit queue_it);
        m_item_t     seq[$];
        logic [15:0] rgb;
        logic [7:0]  coord;
        int          n;
        case (it.action)
            ACT_WINDOW: begin
                seq.push_back(make_byte(CMD_CASET, 1'b0, 1'b0));
                seq.push_back(make_byte(ADDR_HIGH, 1'b1, 1'b0));
                coord = it.x_start + 8'(col_offset_q);      // wraps mod 256
                seq.push_back(make_byte(coord, 1'b1, 1'b0));
                seq.push_back(make_byte(ADDR_HIGH, 1'b1, 1'b0));
                coord = it.x_end + 8'(col_offset_q);
                seq.push_back(make_byte(coord, 1'b1, 1'b0));
                seq.push_back(make_byte(CMD_RASET, 1'b0, 1'b0));
                seq.push_back(make_byte(ADDR_HIGH, 1'b1, 1'b0));
                coord = it.y_start + 8'(row_offset_q);
                seq.push_back(make_byte(coord, 1'b1, 1'b0));
                seq.push_back(make_byte(ADDR_HIGH, 1'b1, 1'b0));
                coord = it.y_end + 8'(row_offset_q);
                seq.push_back(make_byte(coord, 1'b1, 1'b0));
                seq.push_back(make_byte(CMD_RAMWR, 1'b0, 1'b0));
                // reversed corners still send the address bytes, but no pixels
                if (it.x_end < it.x_start || it.y_end < it.y_start)
                    pixels_pending = '0;
                else
                    pixels_pending = 17'((int'(it.x_end) - int'(it.x_start) + 1) *
                                         (int'(it.y_end) - int'(it.y_start) + 1));
                fill_rgb = it.fore_color;
            end
            ACT_TICK: begin
                if (pixels_pending != 0) begin
                    seq.push_back(make_byte(fill_rgb[15:8], 1'b1, 1'b0));
                    seq.push_back(make_byte(fill_rgb[7:0], 1'b1, 1'b0));
                    pixels_pending = pixels_pending - 17'd1;
                end
            end
            ACT_GLYPH: begin
                n = it.glyph_wide ? 16 : 8;
                for (int j = 0; j < n; j++) begin
                    rgb = it.glyph_bits[j] ? it.fore_color : it.back_color;
                    seq.push_back(make_byte(rgb[15:8], 1'b1, 1'b0));
                    seq.push_back(make_byte(rgb[7:0], 1'b1, 1'b0));
                end
            end
            default: ;
        endcase
        if (seq.size() > 0)
            seq[seq.size() - 1].last = 1'b1;
        if (queue_it)
            foreach (seq[k]) link_bytes_due.push_back(seq[k]);
        return seq.size();
    endfunction

    function automatic s_item_t pack_request(input logic [1:0] act,
                                             input logic [7:0] xs, input logic [7:0] ys,
                                             input logic [7:0] xe, input logic [7:0] ye,
                                             input logic [15:0] fg, input logic [15:0] bg,
                                             input logic [15:0] bits, input logic wide);
        s_item_t it;
        it.action     = act;
        it.x_start    = xs;
        it.y_start    = ys;
        it.x_end      = xe;
        it.y_end      = ye;
        it.fore_color = fg;
        it.back_color = bg;
        it.glyph_bits = bits;
        it.glyph_wide = wide;
        return it;
    endfunction

    // Mostly well-formed drawing: a window, then ticks to drain it, with glyph
    // rows mixed in. Fields a request does not use carry random junk.
    function automatic s_item_t random_request();
        s_item_t it;
        int      pick;
        int      shape;
        it = pack_request(ACT_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom));
        pick = $urandom_range(0, 99);
        if ((pixels_pending == 0 && pick < 50) || pick < 12) begin
            it.action = ACT_WINDOW;
            shape = $urandom_range(0, 9);
            if (shape < 7) begin
                // small window; a start near 255 wraps the end and reverses it
                it.x_end = it.x_start + 8'($urandom_range(0, 3));
                it.y_end = it.y_start + 8'($urandom_range(0, 3));
            end else if (shape == 7) begin
                // hugs the far edge, so the offset pushes the address past 255
                it.x_start = 8'($urandom_range(250, 255));
                it.x_end   = 8'hFF;
                it.y_start = 8'($urandom_range(250, 255));
                it.y_end   = 8'hFF;
            end
            // other shapes keep fully random corners, often reversed
        end else if (pick < 70) begin
            it.action = ACT_TICK;
        end else if (pick < 92) begin
            it.action = ACT_GLYPH;
        end else begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // bursts of random length, separated by random gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Presents one item, holds it until taken, then books what it should cause.
    // Called at a rising edge; returns at a rising edge.
    task automatic offer_request(input s_item_t it, input logic typed,
                                 input logic [1:0] typed_n, input logic [15:0] typed_word);
        int produced;
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        produced = expand_request(it, !typed);
        if (typed) begin
            for (int k = 0; k < typed_n; k++)
                link_bytes_due.push_back(make_byte(k == 0 ? typed_word[15:8]
                                                          : typed_word[7:0],
                                                   1'b1, k == typed_n - 1));
        end
        items_accepted++;
        if (produced > 0)
            items_with_out++;
        case (it.action)
            ACT_WINDOW: windows_sent++;
            ACT_TICK:   ticks_sent++;
            ACT_GLYPH:  glyphs_sent++;
            default:    ignored_sent++;
        endcase
        pace_sender();
    endtask

    // Stop sending until every owed byte is out, then give silent items
    // (empty ticks, code 3) time to clear the block.
    task automatic wait_link_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (link_bytes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both offsets, one write each, block idle
    task automatic write_offsets(input logic [1:0] col_val, input logic [1:0] row_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COL_OFFSET;
        cfg_wdata <= col_val;
        @(posedge aclk);
        col_offset_q = col_val;
        cfg_index <= CFG_ROW_OFFSET;
        cfg_wdata <= row_val;
        @(posedge aclk);
        row_offset_q = row_val;
        cfg_wr_en <= 1'b0;
        offset_sets++;
    endtask

    task automatic add_row(input s_item_t it, input logic typed, input logic [1:0] typed_n,
                           input logic [15:0] typed_word);
        opening_row_t r;
        r.item       = it;
        r.typed      = typed;
        r.typed_n    = typed_n;
        r.typed_word = typed_word;
        opening_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: stall pattern changes mode every so often
    //   0 always ready, 1 every other cycle, 2 coin flip, 3 one cycle in four
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        slow_phase <= slow_phase + 2'd1;
        if (stall_hold == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_hold <= $urandom_range(16, 160);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        case (stall_mode)
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ~m_ready;
            2'd2:    m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= (slow_phase == 2'd0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Checker: each accepted byte against the oldest owed one
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            bytes_checked++;
            if (link_bytes_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected byte %h is_data %b last %b",
                                        m_item.out_byte, m_item.is_data, m_item.last));
            end else begin
                link_want = link_bytes_due.pop_front();
                if (m_item.out_byte !== link_want.out_byte)
                    flag_mismatch($sformatf("out_byte %h, want %h",
                                            m_item.out_byte, link_want.out_byte));
                if (m_item.is_data !== link_want.is_data)
                    flag_mismatch($sformatf("is_data %b, want %b (byte %h)",
                                            m_item.is_data, link_want.is_data,
                                            link_want.out_byte));
                if (m_item.last !== link_want.last)
                    flag_mismatch($sformatf("last %b, want %b (byte %h)",
                                            m_item.last, link_want.last,
                                            link_want.out_byte));
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("TIMEOUT after %0d cycles, %0d bytes still owed",
                 cycle_count, link_bytes_due.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [1:0] col_set;
        logic [1:0] row_set;
        int         phase_base;

        // Directed table, run at the reset offsets (column 2, row 1).
        // Typed rows: pixel colours and silent items, readable at a glance.
        // tick straight after reset has no window behind it
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd0, 16'h0000);
        // code 3 with every field high: swallowed
        add_row(pack_request(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1, 2'd0, 16'h0000);
        // single-pixel window, one colour, then nothing left
        add_row(pack_request(ACT_WINDOW, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'hFFFF, 16'h0000, 16'h0000, 1'b0), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd2, 16'hFFFF);
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd0, 16'h0000);
        // far corner: offset addresses wrap past 255
        add_row(pack_request(ACT_WINDOW, 8'd250, 8'd253, 8'd255, 8'd255,
                             16'h0001, 16'h0000, 16'h0000, 1'b0), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd2, 16'h0001);
        // reversed columns: addresses go out, pixel count is zero
        add_row(pack_request(ACT_WINDOW, 8'd10, 8'd0, 8'd9, 8'd255,
                             16'h1234, 16'h0000, 16'h0000, 1'b0), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd0, 16'h0000);
        // reversed rows
        add_row(pack_request(ACT_WINDOW, 8'd0, 8'd200, 8'd255, 8'd100,
                             16'h4321, 16'h0000, 16'h0000, 1'b0), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd0, 16'h0000);
        // full 256 x 256 screen, count needs all 17 bits
        add_row(pack_request(ACT_WINDOW, 8'd0, 8'd0, 8'd255, 8'd255,
                             16'hA55A, 16'h0000, 16'h0000, 1'b0), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd2, 16'hA55A);
        // glyph rows: narrow, narrow with upper bits set (ignored), wide extremes
        add_row(pack_request(ACT_GLYPH, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'hF800, 16'h07E0, 16'h00A5, 1'b0), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_GLYPH, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'hFFFF, 16'h0000, 16'hFF00, 1'b0), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_GLYPH, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_GLYPH, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h1F1F, 16'hE0E0, 16'h8001, 1'b1), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_GLYPH, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'hFFFF, 16'h5AA5, 16'h0000, 1'b1), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd0, 16'h0000);
        // glyphs and code 3 must leave the fill colour and count alone
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd2, 16'hA55A);
        // 1x1 at 255,255: column wraps to 1, row to 0
        add_row(pack_request(ACT_WINDOW, 8'd255, 8'd255, 8'd255, 8'd255,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b0, 2'd0, 16'h0000);
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1), 1'b1, 2'd2, 16'h0000);
        add_row(pack_request(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00,
                             16'h0000, 16'h0000, 16'h0000, 1'b0), 1'b1, 2'd0, 16'h0000);

        // hold reset, then leave it alone
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (opening_rows[i])
            offer_request(opening_rows[i].item, opening_rows[i].typed,
                          opening_rows[i].typed_n, opening_rows[i].typed_word);

        // random phases; each new offset setting only once the link is quiet
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin col_set = 2'd0; row_set = 2'd0; end
                1: begin col_set = 2'd3; row_set = 2'd3; end
                2: begin col_set = 2'd1; row_set = 2'd2; end
                default: begin
                    col_set = 2'($urandom_range(0, 3));
                    row_set = 2'($urandom_range(0, 3));
                end
            endcase
            wait_link_drained();
            write_offsets(col_set, row_set);
            burst_left = 0;
            phase_base = items_with_out;
            while (items_with_out - phase_base < PHASE_REQUESTS) begin
                offer_request(random_request(), 1'b0, 2'd0, 16'h0000);
                // now and then hold the sender until the link has caught up
                if ($urandom_range(0, 39) == 0)
                    wait_link_drained();
            end
        end

        wait_link_drained();

        $display("Run covered %0d requests: %0d windows, %0d ticks, %0d glyph rows, %0d ignored",
                 items_accepted, windows_sent, ticks_sent, glyphs_sent, ignored_sent);
        $display("%0d link bytes checked over %0d offset settings, %0d mismatches",
                 bytes_checked, offset_sets, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lcdw_pkg.sv
rtl/lcdw_front.sv
rtl/lcdw_job_fifo.sv
rtl/lcdw_back.sv
rtl/lcd_window_pixel_stream_top.sv
rtl/lcdw_checker.sv
tb/sv/testbench.sv
